// ===== hw/rtl/eyvm_pkg.sv =====
// Package with the shared types and constants of the Y-X-Z Euler view matrix unit.
`timescale 1ns / 1ps
package eyvm_pkg;

   // Sine polynomial coefficients in Q30.
   localparam logic [31:0] POLY_C1 = 32'd1686629713;
   localparam logic [31:0] POLY_C3 = 32'd693598668;
   localparam logic [31:0] POLY_C5 = 32'd85569306;
   localparam logic [31:0] POLY_C7 = 32'd5026995;
   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
   localparam logic [31:0] HALF_Q30 = 32'h2000_0000;

   // Sine evaluation state for one angle.
   typedef struct packed {
      logic [31:0] t;
      logic [31:0] t2;
      logic [31:0] p;
      logic        neg;
   } sin_stage_type;

endpackage

// ===== hw/rtl/eyvm_sin_pipe.sv =====
// Pipelined sine of a binary angle: polynomial in Q30, rounded to FRAC_BITS.
`timescale 1ns / 1ps
module eyvm_sin_pipe #(
   parameter int ANGLE_BITS = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic                   clock,
   input  logic                   advance,
   input  logic [ANGLE_BITS-1:0]  angle,
   output logic signed [FRAC_BITS+1:0] sine
);
   localparam int NST = 5;
   localparam int SH  = 30 - FRAC_BITS;
   localparam logic [63:0] RND = 64'd1 << (SH - 1);

   eyvm_pkg::sin_stage_type st_ff [NST];
   eyvm_pkg::sin_stage_type st_in [NST];
   logic signed [FRAC_BITS+1:0] sine_ff, sine_in;

   function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] pr;
      pr = {32'd0, a} * {32'd0, b} + {32'd0, eyvm_pkg::HALF_Q30};
      return pr[61:30];
   endfunction

   // Stage 0: quadrant fold and t squared; stages 1 to 3: Horner steps; stage 4: product with t.
   always_comb begin
      logic [1:0]  quad;
      logic [31:0] t;
      quad = angle[ANGLE_BITS-1 -: 2];
      t = 32'({angle[ANGLE_BITS-3:0]}) << (32 - ANGLE_BITS);
      if (quad[0]) begin
         t = eyvm_pkg::ONE_Q30 - t;
      end
      st_in[0].t   = t;
      st_in[0].t2  = qmul(t, t);
      st_in[0].p   = eyvm_pkg::POLY_C7;
      st_in[0].neg = quad[1];

      st_in[1] = st_ff[0];
      st_in[2] = st_ff[1];
      st_in[3] = st_ff[2];
      st_in[1].p = eyvm_pkg::POLY_C5 - qmul(st_ff[0].p, st_ff[0].t2);
      st_in[2].p = eyvm_pkg::POLY_C3 - qmul(st_ff[1].p, st_ff[1].t2);
      st_in[3].p = eyvm_pkg::POLY_C1 - qmul(st_ff[2].p, st_ff[2].t2);
      st_in[4] = st_ff[3];
      st_in[4].p = qmul(st_ff[3].p, st_ff[3].t);
   end

   // Final clamp, rounding and sign.
   always_comb begin
      logic [63:0] s;
      s = {32'd0, st_ff[4].p};
      if (s > {32'd0, eyvm_pkg::ONE_Q30}) begin
         s = {32'd0, eyvm_pkg::ONE_Q30};
      end
      s = (s + RND) >> SH;
      sine_in = st_ff[4].neg ? -$signed(s[FRAC_BITS+1:0]) : $signed(s[FRAC_BITS+1:0]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NST; i++) begin
            st_ff[i] <= st_in[i];
         end
         sine_ff <= sine_in;
      end
   end

   assign sine = sine_ff;
endmodule

// ===== hw/rtl/euler_yxz_view_matrix_unit.sv =====
// Top level of the Y-X-Z Euler view matrix unit.
//
// One pose item enters on the req_ channel (position and three angles) and one
// view transform item leaves on the rsp_ channel (nine Q entries, three
// Q16.16 translations). The block is a stall-together pipeline of 11 register
// stages: six sine units (six stages each), two product stages for the
// entries, and three stages for the translation dot products, the last of
// which is the output register. Throughput is one item per cycle while
// rsp_tready is high. When the receiver stalls the whole pipeline holds;
// req_tready follows rsp_tready or a free output slot, so nothing is lost or
// repeated. Reset clears the valid bits only.
`timescale 1ns / 1ps
module euler_yxz_view_matrix_unit #(
   parameter int ANGLE_BITS = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // pos_x, pos_y, pos_z, yaw_angle, pitch_angle, roll_angle (lowest first)
   input  logic [143:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // u_x u_y u_z v_x v_y v_z w_x w_y w_z (16 each), trans_x trans_y trans_z (32 each)
   output logic [239:0]  rsp_tdata
);
   localparam int NV  = 11;
   localparam int EW  = FRAC_BITS + 2;
   localparam int PW  = 2 * EW;
   localparam logic signed [PW-1:0] EHALF = PW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [EW-1:0] EONE  = EW'(1) <<< FRAC_BITS;

   logic [NV-1:0] vld_ff, vld_in;
   logic          advance;

   assign advance    = rsp_tready || !vld_ff[NV-1];
   assign req_tready = advance;
   assign rsp_tvalid = vld_ff[NV-1];

   // Valid bits travel with the data.
   assign vld_in = {vld_ff[NV-2:0], req_tvalid};
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   logic [ANGLE_BITS-1:0] ang [3];
   logic [ANGLE_BITS-1:0] angc [3];
   logic signed [EW-1:0]  sv [3];
   logic signed [EW-1:0]  cv [3];
   assign ang[0] = ANGLE_BITS'(req_tdata[96 +: 16]);
   assign ang[1] = ANGLE_BITS'(req_tdata[112 +: 16]);
   assign ang[2] = ANGLE_BITS'(req_tdata[128 +: 16]);

   // Sine and cosine units for the three angles.
   for (genvar g = 0; g < 3; g++) begin : g_trig
      assign angc[g] = ang[g] + (ANGLE_BITS'(1) << (ANGLE_BITS - 2));
      eyvm_sin_pipe #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sin (
         .clock(clock), .advance(advance), .angle(ang[g]), .sine(sv[g]));
      eyvm_sin_pipe #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_cos (
         .clock(clock), .advance(advance), .angle(angc[g]), .sine(cv[g]));
   end

   // Position delay line matching the sine latency.
   logic [95:0] pos_ff [6];
   always_ff @(posedge clock) begin
      if (advance) begin
         pos_ff[0] <= req_tdata[95:0];
         for (int i = 1; i < 6; i++) begin
            pos_ff[i] <= pos_ff[i-1];
         end
      end
   end

   function automatic logic signed [EW-1:0] emul(input logic signed [EW-1:0] a,
                                                 input logic signed [EW-1:0] b);
      logic signed [PW-1:0] pr;
      pr = (PW'(a) * PW'(b) + EHALF) >>> FRAC_BITS;
      return pr[EW-1:0];
   endfunction

   function automatic logic signed [EW-1:0] eclamp(input logic signed [EW:0] v);
      if (v > (EW+1)'(EONE)) begin
         return EONE;
      end
      if (v < -(EW+1)'(EONE)) begin
         return -EONE;
      end
      return v[EW-1:0];
   endfunction

   // Entry stage A: first products.
   logic signed [EW-1:0] s1_ff, c1_ff, s2_ff, c2_ff, s3_ff, c3_ff, s1s2_ff, c1s2_ff;
   logic [95:0] posa_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= sv[0]; c1_ff <= cv[0];
         s2_ff <= sv[1]; c2_ff <= cv[1];
         s3_ff <= sv[2]; c3_ff <= cv[2];
         s1s2_ff <= emul(sv[0], sv[1]);
         c1s2_ff <= emul(cv[0], sv[1]);
         posa_ff <= pos_ff[5];
      end
   end

   // Entry stage B: the nine matrix entries.
   logic signed [EW-1:0] m_ff [9];
   logic signed [EW-1:0] m_in [9];
   logic [95:0] posb_ff;
   always_comb begin
      m_in[0] = eclamp((EW+1)'(emul(c1_ff, c3_ff)) + (EW+1)'(emul(s1s2_ff, s3_ff)));
      m_in[1] = emul(c2_ff, s3_ff);
      m_in[2] = eclamp((EW+1)'(emul(c1s2_ff, s3_ff)) - (EW+1)'(emul(c3_ff, s1_ff)));
      m_in[3] = eclamp((EW+1)'(emul(s1s2_ff, c3_ff)) - (EW+1)'(emul(c1_ff, s3_ff)));
      m_in[4] = emul(c2_ff, c3_ff);
      m_in[5] = eclamp((EW+1)'(emul(c1s2_ff, c3_ff)) + (EW+1)'(emul(s1_ff, s3_ff)));
      m_in[6] = emul(c2_ff, s1_ff);
      m_in[7] = -s2_ff;
      m_in[8] = emul(c1_ff, c2_ff);
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         m_ff <= m_in;
         posb_ff <= posa_ff;
      end
   end

   // Dot stage 1: nine products, each 16 by 32 bits.
   localparam int DW = EW + 32;
   logic signed [DW-1:0] pr_ff [9];
   logic signed [EW-1:0] mc_ff [9];
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 9; k++) begin
            pr_ff[k] <= DW'(m_ff[k]) * DW'($signed(posb_ff[32*(k%3) +: 32]));
         end
         mc_ff <= m_ff;
      end
   end

   // Dot stage 2: sums of three.
   logic signed [DW+1:0] d_ff [3];
   logic signed [EW-1:0] md_ff [9];
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            d_ff[k] <= (DW+2)'(pr_ff[3*k]) + (DW+2)'(pr_ff[3*k+1]) + (DW+2)'(pr_ff[3*k+2]);
         end
         md_ff <= mc_ff;
      end
   end

   // Dot stage 3: negate, round and saturate into the output register.
   logic [239:0] out_ff, out_in;
   always_comb begin
      logic signed [DW+2:0] r;
      out_in = '0;
      for (int k = 0; k < 9; k++) begin
         out_in[16*k +: 16] = 16'(md_ff[k]);
      end
      for (int k = 0; k < 3; k++) begin
         r = (-(DW+3)'(d_ff[k]) + (DW+3)'(EHALF)) >>> FRAC_BITS;
         if (r > (DW+3)'(64'sh7FFF_FFFF)) begin
            out_in[144 + 32*k +: 32] = 32'h7FFF_FFFF;
         end else if (r < -(DW+3)'(64'sh8000_0000)) begin
            out_in[144 + 32*k +: 32] = 32'h8000_0000;
         end else begin
            out_in[144 + 32*k +: 32] = r[31:0];
         end
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tdata = out_ff;
endmodule

// ===== sim/euler_yxz_view_matrix_unit_test.sv =====
// Self-checking testbench for the Y-X-Z Euler view matrix unit.
`timescale 1ns / 1ps
module euler_yxz_view_matrix_unit_test;

   localparam int ANGLE_BITS = 16;
   localparam int FRAC_BITS  = 14;
   localparam int NUM_RANDOM = 750;
   localparam int CYCLE_LIMIT = 200000;
   localparam longint QUARTER_TURN = 64'd1 << (ANGLE_BITS - 2);
   localparam longint ENTRY_ONE = 64'd1 << FRAC_BITS;
   localparam longint ENTRY_HALF = 64'd1 << (FRAC_BITS - 1);
   localparam longint Q30_ONE = 64'd1 << 30;

   // One camera pose as it travels on the request channel.
   typedef struct {
      logic signed [31:0] px, py, pz;
      logic [15:0]        yaw, pitch, roll;
   } pose_type;

   // Directed pose with an optional typed-in view transform.
   typedef struct {
      pose_type     pose;
      bit           known;
      logic [239:0] view;
   } pose_row_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   // pos_x, pos_y, pos_z, yaw_angle, pitch_angle, roll_angle (lowest first)
   logic [143:0]  req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   // u_x u_y u_z v_x v_y v_z w_x w_y w_z (16 each), trans_x trans_y trans_z (32 each)
   logic [239:0]  rsp_tdata;

   logic [239:0]  expected_views[$];
   int            mismatches;
   int            cycles;
   bit            sending_done;
   bit            hold_off;
   bit            steady_phase;
   pose_row_type  pose_rows[$];

   euler_yxz_view_matrix_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Floor division by a power of two.
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint q30_product(longint a, longint b);
      return (a * b + (Q30_ONE >> 1)) >> 30;
   endfunction

   // Polynomial sine of a binary angle, in FRAC_BITS fixed point.
   function automatic longint angle_sine(longint ang);
      longint a, t, t2, p, s;
      int quad;
      a = ang & ((64'd1 << ANGLE_BITS) - 1);
      quad = int'((a >> (ANGLE_BITS - 2)) & 3);
      t = (a & (QUARTER_TURN - 1)) << (32 - ANGLE_BITS);
      if (quad[0]) begin
         t = Q30_ONE - t;
      end
      t2 = q30_product(t, t);
      p = 5026995;
      p = 85569306 - q30_product(p, t2);
      p = 693598668 - q30_product(p, t2);
      p = 1686629713 - q30_product(p, t2);
      s = q30_product(p, t);
      if (s > Q30_ONE) begin
         s = Q30_ONE;
      end
      s = (s + ((64'd1 << (30 - FRAC_BITS)) >> 1)) >> (30 - FRAC_BITS);
      return quad[1] ? -s : s;
   endfunction

   function automatic longint entry_product(longint a, longint b);
      return floor_shift(a * b + ENTRY_HALF, FRAC_BITS);
   endfunction

   function automatic longint entry_clamp(longint v);
      if (v > ENTRY_ONE) begin
         return ENTRY_ONE;
      end
      if (v < -ENTRY_ONE) begin
         return -ENTRY_ONE;
      end
      return v;
   endfunction

   // Negated dot product of one basis row with the position, saturated.
   function automatic logic [31:0] translation(longint b0, longint b1, longint b2,
                                               pose_type ps);
      longint d, r;
      d = b0 * longint'(ps.px) + b1 * longint'(ps.py) + b2 * longint'(ps.pz);
      r = floor_shift(-d + ENTRY_HALF, FRAC_BITS);
      if (r > 64'sd2147483647) begin
         r = 64'sd2147483647;
      end
      if (r < -64'sd2147483648) begin
         r = -64'sd2147483648;
      end
      return r[31:0];
   endfunction

   // Full view transform of one pose, packed as on the response channel.
   function automatic logic [239:0] view_of_pose(pose_type ps);
      longint s1, c1, s2, c2, s3, c3, s1s2, c1s2;
      longint m[9];
      logic [239:0] v;
      s1 = angle_sine(ps.yaw);
      c1 = angle_sine(longint'(ps.yaw) + QUARTER_TURN);
      s2 = angle_sine(ps.pitch);
      c2 = angle_sine(longint'(ps.pitch) + QUARTER_TURN);
      s3 = angle_sine(ps.roll);
      c3 = angle_sine(longint'(ps.roll) + QUARTER_TURN);
      s1s2 = entry_product(s1, s2);
      c1s2 = entry_product(c1, s2);
      m[0] = entry_clamp(entry_product(c1, c3) + entry_product(s1s2, s3));
      m[1] = entry_product(c2, s3);
      m[2] = entry_clamp(entry_product(c1s2, s3) - entry_product(c3, s1));
      m[3] = entry_clamp(entry_product(s1s2, c3) - entry_product(c1, s3));
      m[4] = entry_product(c2, c3);
      m[5] = entry_clamp(entry_product(c1s2, c3) + entry_product(s1, s3));
      m[6] = entry_product(c2, s1);
      m[7] = -s2;
      m[8] = entry_product(c1, c2);
      v = '0;
      for (int k = 0; k < 9; k++) begin
         v[16*k +: 16] = m[k][15:0];
      end
      v[144 +: 32] = translation(m[0], m[1], m[2], ps);
      v[176 +: 32] = translation(m[3], m[4], m[5], ps);
      v[208 +: 32] = translation(m[6], m[7], m[8], ps);
      return v;
   endfunction

   function automatic pose_type make_pose(int px, int py, int pz, int yaw, int pitch,
                                          int roll);
      pose_type ps;
      ps.px = px; ps.py = py; ps.pz = pz;
      ps.yaw = 16'(yaw); ps.pitch = 16'(pitch); ps.roll = 16'(roll);
      return ps;
   endfunction

   function automatic pose_type random_pose();
      pose_type ps;
      ps.px = $urandom; ps.py = $urandom; ps.pz = $urandom;
      ps.yaw = 16'($urandom); ps.pitch = 16'($urandom); ps.roll = 16'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         // Small positions keep translations in range most of the time.
         ps.px = $signed(ps.px) >>> $urandom_range(4, 20);
         ps.py = $signed(ps.py) >>> $urandom_range(4, 20);
         ps.pz = $signed(ps.pz) >>> $urandom_range(4, 20);
      end
      return ps;
   endfunction

   // Zero angles at a given position; the polynomial does not give exact unit
   // entries there, so the predictor supplies the expected view.
   function automatic pose_row_type identity_row(int px, int py, int pz);
      pose_row_type r;
      r.pose = make_pose(px, py, pz, 0, 0, 0);
      r.known = 1'b0;
      r.view = '0;
      return r;
   endfunction

   function automatic pose_row_type plain_row(pose_type ps);
      pose_row_type r;
      r.pose = ps;
      r.known = 1'b0;
      r.view = '0;
      return r;
   endfunction

   // Present one pose and wait until it is accepted.
   task automatic send_pose(pose_type ps, logic [239:0] view);
      while (!steady_phase && $urandom_range(0, 99) < 19) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {ps.roll, ps.pitch, ps.yaw, ps.pz, ps.py, ps.px};
      expected_views.push_back(view);
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Sender: directed table, then random poses.
   initial begin
      pose_type ps;
      req_tvalid = 1'b0;
      req_tdata = '0;
      reset = 1'b1;
      sending_done = 1'b0;
      steady_phase = 1'b0;
      pose_rows.push_back(identity_row(0, 0, 0));
      pose_rows.push_back(identity_row(32'h0001_0000, -32'sh0002_0000, 32'h0000_8000));
      pose_rows.push_back(identity_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      pose_rows.push_back(identity_row(1, -1, 32'h1234_5678));
      // Translation saturation at both ends.
      pose_rows.push_back(plain_row(make_pose(32'h8000_0000, 32'h8000_0000,
                                              32'h8000_0000, 0, 0, 0)));
      pose_rows.push_back(plain_row(make_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                              32'h7FFF_FFFF, 16'h2000, 16'hE000, 16'h2000)));
      pose_rows.push_back(plain_row(make_pose(32'h8000_0000, 32'h7FFF_FFFF,
                                              32'h8000_0000, 16'h6000, 16'h2000, 16'hA000)));
      // Quadrant boundaries and all-ones angles.
      for (int q = 0; q < 4; q++) begin
         pose_rows.push_back(plain_row(make_pose(32'h0003_0000, 32'hFFFF_0000, 32'h0000_4000,
                                                 q * 16384, (q + 1) * 16384, (q + 2) * 16384)));
      end
      pose_rows.push_back(plain_row(make_pose(-1, -1, -1, 16'hFFFF, 16'hFFFF, 16'hFFFF)));
      pose_rows.push_back(plain_row(make_pose(5, 6, 7, 16'h3FFF, 16'h4001, 16'hBFFF)));
      pose_rows.push_back(plain_row(make_pose(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                                              16'h5555, 16'hAAAA, 16'h0001)));
      pose_rows.push_back(plain_row(make_pose(32'h0100_0000, 0, 0, 16'h8000, 16'h8000,
                                              16'h8000)));
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (pose_rows[i]) begin
         send_pose(pose_rows[i].pose, pose_rows[i].known ? pose_rows[i].view
                                                        : view_of_pose(pose_rows[i].pose));
      end
      for (int n = 0; n < NUM_RANDOM; n++) begin
         steady_phase = (n >= 300 && n < 400);
         ps = random_pose();
         send_pose(ps, view_of_pose(ps));
      end
      req_tvalid <= 1'b0;
      sending_done = 1'b1;
   end

   // Receiver readiness: random stalls, one long hold-off, and a stall-free stretch.
   initial begin
      int held;
      rsp_tready = 1'b0;
      hold_off = 1'b0;
      held = 0;
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         @(negedge clock);
         if (!hold_off && held == 0 && cycles > 200) begin
            hold_off = 1'b1;
         end
         if (hold_off) begin
            held++;
            rsp_tready <= 1'b0;
            if (held >= 80) begin
               hold_off = 1'b0;
            end
         end else begin
            rsp_tready <= steady_phase || ($urandom_range(0, 99) >= 19);
         end
      end
   end

   // Response checking against the oldest expectation.
   always @(posedge clock) begin
      logic [239:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_views.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected view item %h", rsp_tdata);
            end
         end else begin
            want = expected_views.pop_front();
            for (int k = 0; k < 12; k++) begin
               if (k < 9 ? rsp_tdata[16*k +: 16] != want[16*k +: 16]
                         : rsp_tdata[144+32*(k-9) +: 32] != want[144+32*(k-9) +: 32]) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("field %0d mismatch: expected %h actual %h", k, want, rsp_tdata);
                  end
               end
            end
         end
      end
   end

   // Cycle count, end of run and timeout.
   initial begin
      mismatches = 0;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
         if (sending_done && expected_views.size() == 0) begin
            repeat (30) @(posedge clock);
            if (mismatches == 0) begin
               $display("[ OK ] regression clean");
            end else begin
               $display("[FAIL] regression broken");
            end
            $finish;
         end
      end
   end

endmodule
